// ===== rtl/rrcs_pkg.sv =====
`timescale 1ns / 1ps

package rrcs_pkg;

	localparam int PAIRS = 6;
	// one context row per frame pair, plus one row for the page directory
	localparam int ROWS = PAIRS + 1;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_ADD  = 2'd1;
	localparam logic [1:0] REQ_SET  = 2'd2;

	localparam logic [1:0] TS_READY   = 2'd0;
	localparam logic [1:0] TS_RUNNING = 2'd1;

	localparam logic [2:0] STAT_SWITCHED = 3'd0;
	localparam logic [2:0] STAT_KEPT     = 3'd1;
	localparam logic [2:0] STAT_NO_TASKS = 3'd2;
	localparam logic [2:0] STAT_ADDED    = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;
	localparam logic [2:0] STAT_SET      = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  target_slot;
		logic [1:0]  task_state_in;
		logic [31:0] page_dir_in;
		logic [63:0] frame_pair_a;
		logic [63:0] frame_pair_b;
		logic [63:0] frame_pair_c;
		logic [63:0] frame_pair_d;
		logic [63:0] frame_pair_e;
		logic [63:0] frame_pair_f;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  running_slot;
		logic [3:0]  assigned_slot;
		logic        load_page_dir;
		logic [31:0] page_dir_out;
		logic [63:0] out_pair_a;
		logic [63:0] out_pair_b;
		logic [63:0] out_pair_c;
		logic [63:0] out_pair_d;
		logic [63:0] out_pair_e;
		logic [63:0] out_pair_f;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SAVE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RESTORE,
		S_OUT
	} fsm_t;

endpackage

// ===== rtl/round_robin_context_switcher.sv =====
`timescale 1ns / 1ps
// Round-robin task-switch engine over a ring of task slots kept in memory.
// A tick saves the current task's frame pairs and, with more than one task, scans the
// state memory slot by slot (a read state and a check state per slot) for a ready task
// whose context and page directory are then restored; with none found it keeps the task.
// One request is worked on at a time; a finished result waits in the output register.
// Reset clears the task count, current slot and control; the memories are not cleared.
module round_robin_context_switcher #(
	parameter int MAX_TASKS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  rrcs_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rrcs_pkg::rsp_t  rsp
);
	import rrcs_pkg::*;

	localparam int SLOT_W = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int AW     = $clog2(MAX_TASKS * ROWS);

	function automatic logic [AW-1:0] row_addr(input logic [SLOT_W-1:0] s,
		input logic [2:0] j);
		return (AW'(s) << 3) - AW'(s) + AW'(j);
	endfunction

	// memories
	logic [63:0] ctx_mem [MAX_TASKS*ROWS];
	logic [1:0]  st_mem  [MAX_TASKS];

	logic              ctx_we;
	logic [AW-1:0]     ctx_waddr, ctx_raddr;
	logic [63:0]       ctx_wdata, ctx_rdata_q;
	logic              st_we;
	logic [SLOT_W-1:0] st_waddr, st_raddr;
	logic [1:0]        st_wdata, st_rdata_q;

	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem[ctx_waddr] <= ctx_wdata;
		end
		ctx_rdata_q <= ctx_mem[ctx_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		st_rdata_q <= st_mem[st_raddr];
	end

	// control and datapath registers
	fsm_t              state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] current_q;
	logic [SLOT_W-1:0] nxt_q;
	logic [CNT_W-1:0]  k_q;
	logic [2:0]        j_q;
	logic [1:0]        cur_st_q;
	logic [63:0]       frame_q [PAIRS];
	logic [31:0]       pd_q;
	logic [2:0]        res_status_q;
	logic [3:0]        res_assigned_q;
	logic              res_load_q;
	logic              res_zero_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              full;
	logic              tgt_ok;
	logic [SLOT_W+3:0] tgt_ext;
	logic [SLOT_W+3:0] cur_ext;
	logic [SLOT_W+3:0] cnt_slot_ext;
	logic [CNT_W-1:0]  cur_inc, nxt_inc;
	logic [SLOT_W-1:0] cur_succ, nxt_succ;
	logic              out_free;
	logic              last_probe;

	assign accept       = req_valid && !req_stall;
	assign full         = (count_q == CNT_W'(MAX_TASKS));
	assign tgt_ext      = {{SLOT_W{1'b0}}, req.target_slot};
	assign tgt_ok       = ({{CNT_W{1'b0}}, req.target_slot} < {4'b0000, count_q});
	assign cur_ext      = {4'b0000, current_q};
	assign cnt_slot_ext = {4'b0000, count_q[SLOT_W-1:0]};
	assign cur_inc      = CNT_W'(current_q) + CNT_W'(1);
	assign nxt_inc      = CNT_W'(nxt_q) + CNT_W'(1);
	assign cur_succ     = (cur_inc == count_q) ? '0 : cur_inc[SLOT_W-1:0];
	assign nxt_succ     = (nxt_inc == count_q) ? '0 : nxt_inc[SLOT_W-1:0];
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign last_probe   = (k_q == count_q - CNT_W'(1));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctx_we    = 1'b0;
		ctx_waddr = row_addr(current_q, j_q);
		ctx_wdata = 64'd0;
		ctx_raddr = row_addr(nxt_q, j_q);
		st_we     = 1'b0;
		st_waddr  = current_q;
		st_wdata  = TS_RUNNING;
		st_raddr  = current_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_ADD: begin
							if (!full) begin
								st_we    = 1'b1;
								st_waddr = count_q[SLOT_W-1:0];
								st_wdata = req.task_state_in;
								state_d  = S_ADD;
							end else begin
								state_d = S_OUT;
							end
						end
						REQ_TICK: begin
							state_d = (count_q == '0) ? S_OUT : S_SAVE;
						end
						default: begin
							if (req.req_type == REQ_SET && tgt_ok) begin
								st_we    = 1'b1;
								st_waddr = tgt_ext[SLOT_W-1:0];
								st_wdata = req.task_state_in;
							end
							state_d = S_OUT;
						end
					endcase
				end
			end
			S_ADD: begin
				ctx_we    = 1'b1;
				ctx_waddr = row_addr(count_q[SLOT_W-1:0], j_q);
				ctx_wdata = (j_q == 3'(PAIRS)) ? {32'd0, pd_q} : frame_q[j_q];
				if (j_q == 3'(PAIRS)) begin
					state_d = S_OUT;
				end
			end
			S_SAVE: begin
				ctx_we    = 1'b1;
				ctx_wdata = frame_q[j_q];
				if (j_q == 3'(PAIRS - 1)) begin
					if (count_q == CNT_W'(1)) begin
						// lone task: force it back to running
						st_we   = 1'b1;
						state_d = S_OUT;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				st_raddr = nxt_q;
				state_d  = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (st_rdata_q == TS_READY) begin
					st_we    = 1'b1;
					st_waddr = nxt_q;
					state_d  = S_RESTORE;
				end else if (last_probe) begin
					st_we   = 1'b1;
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_RESTORE: begin
				// demote the interrupted task while the context streams out
				if (j_q == 3'd0 && cur_st_q == TS_RUNNING) begin
					st_we    = 1'b1;
					st_wdata = TS_READY;
				end
				if (j_q == 3'(ROWS)) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			current_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_ADD && j_q == 3'(PAIRS)) begin
				if (count_q == '0) begin
					current_q <= '0;
				end
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == S_RESTORE && j_q == 3'(ROWS)) begin
				current_q <= nxt_q;
			end
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				j_q   <= '0;
				k_q   <= CNT_W'(1);
				nxt_q <= cur_succ;
				pd_q  <= req.page_dir_in;
				frame_q[0] <= req.frame_pair_a;
				frame_q[1] <= req.frame_pair_b;
				frame_q[2] <= req.frame_pair_c;
				frame_q[3] <= req.frame_pair_d;
				frame_q[4] <= req.frame_pair_e;
				frame_q[5] <= req.frame_pair_f;
				res_load_q     <= 1'b0;
				unique case (req.req_type)
					REQ_ADD: begin
						res_status_q   <= full ? STAT_FULL : STAT_ADDED;
						res_assigned_q <= full ? 4'd0 : cnt_slot_ext[3:0];
						res_zero_q     <= 1'b1;
					end
					REQ_TICK: begin
						res_status_q   <= STAT_NO_TASKS;
						res_assigned_q <= '0;
						res_zero_q     <= 1'b0;
					end
					default: begin
						res_status_q   <= STAT_SET;
						res_assigned_q <= '0;
						res_zero_q     <= 1'b1;
					end
				endcase
			end
			S_ADD: begin
				j_q <= j_q + 3'd1;
			end
			S_SAVE: begin
				if (j_q == 3'd0) begin
					cur_st_q <= st_rdata_q;
				end
				j_q <= (j_q == 3'(PAIRS - 1)) ? 3'd0 : j_q + 3'd1;
				res_status_q <= STAT_KEPT;
			end
			S_SCAN_CHK: begin
				if (st_rdata_q != TS_READY) begin
					k_q   <= k_q + CNT_W'(1);
					nxt_q <= nxt_succ;
				end
			end
			S_RESTORE: begin
				// the memory read is registered, so the data belongs to the previous row address
				if (j_q != 3'd0) begin
					if (j_q == 3'(ROWS)) begin
						pd_q <= ctx_rdata_q[31:0];
					end else begin
						frame_q[j_q - 3'd1] <= ctx_rdata_q;
					end
				end
				j_q          <= j_q + 3'd1;
				res_status_q <= STAT_SWITCHED;
				res_load_q   <= 1'b1;
			end
			S_OUT: begin
				if (out_free) begin
					rsp_q.status        <= res_status_q;
					rsp_q.running_slot  <= cur_ext[3:0];
					rsp_q.assigned_slot <= res_assigned_q;
					rsp_q.load_page_dir <= res_load_q;
					rsp_q.page_dir_out  <= res_load_q ? pd_q : 32'd0;
					rsp_q.out_pair_a    <= res_zero_q ? 64'd0 : frame_q[0];
					rsp_q.out_pair_b    <= res_zero_q ? 64'd0 : frame_q[1];
					rsp_q.out_pair_c    <= res_zero_q ? 64'd0 : frame_q[2];
					rsp_q.out_pair_d    <= res_zero_q ? 64'd0 : frame_q[3];
					rsp_q.out_pair_e    <= res_zero_q ? 64'd0 : frame_q[4];
					rsp_q.out_pair_f    <= res_zero_q ? 64'd0 : frame_q[5];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rrcs_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam logic [1:0] TS_NOT_READY = 2'd2;
	localparam logic [1:0] TS_ODD_CODE  = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow of the task table
	logic [63:0] shadow_ctx [SLOTS][PAIRS];
	logic [31:0] shadow_pd [SLOTS];
	logic [1:0]  shadow_state [SLOTS];
	int unsigned slots_used = 0;
	logic [3:0]  cur_slot = '0;

	rsp_t switch_results_due [$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	round_robin_context_switcher #(.MAX_TASKS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic rsp_t schedule_request(input req_t r);
		rsp_t o;
		logic [63:0] f [PAIRS];
		logic [63:0] p [PAIRS];
		int unsigned c;
		int unsigned nxt;
		bit found;
		o = '0;
		f = '{r.frame_pair_a, r.frame_pair_b, r.frame_pair_c,
			r.frame_pair_d, r.frame_pair_e, r.frame_pair_f};
		for (int j = 0; j < PAIRS; j++)
			p[j] = '0;
		case (r.req_type)
			REQ_ADD: begin
				if (slots_used >= SLOTS) begin
					o.status = STAT_FULL;
				end else begin
					for (int j = 0; j < PAIRS; j++)
						shadow_ctx[slots_used][j] = f[j];
					shadow_pd[slots_used] = r.page_dir_in;
					shadow_state[slots_used] = r.task_state_in;
					if (slots_used == 0)
						cur_slot = '0;
					o.assigned_slot = slots_used[3:0];
					o.status = STAT_ADDED;
					slots_used++;
				end
			end
			REQ_TICK: begin
				if (slots_used == 0) begin
					o.status = STAT_NO_TASKS;
					p = f;
				end else begin
					c = 32'(cur_slot);
					if (c >= slots_used)
						c = 0;
					for (int j = 0; j < PAIRS; j++)
						shadow_ctx[c][j] = f[j];
					if (shadow_state[c] == TS_RUNNING)
						shadow_state[c] = TS_READY;
					found = 1'b0;
					nxt = c;
					for (int k = 1; k < slots_used && !found; k++) begin
						nxt = (c + k) % slots_used;
						found = (shadow_state[nxt] == TS_READY);
					end
					if (!found) begin
						// no ready task: hold the current one whatever its state
						shadow_state[c] = TS_RUNNING;
						cur_slot = c[3:0];
						o.status = STAT_KEPT;
						p = f;
					end else begin
						shadow_state[nxt] = TS_RUNNING;
						cur_slot = nxt[3:0];
						o.status = STAT_SWITCHED;
						o.load_page_dir = 1'b1;
						o.page_dir_out = shadow_pd[nxt];
						for (int j = 0; j < PAIRS; j++)
							p[j] = shadow_ctx[nxt][j];
					end
				end
			end
			default: begin
				if (r.req_type == REQ_SET && 32'(r.target_slot) < slots_used)
					shadow_state[r.target_slot] = r.task_state_in;
				o.status = STAT_SET;
			end
		endcase
		o.running_slot = cur_slot;
		o.out_pair_a = p[0];
		o.out_pair_b = p[1];
		o.out_pair_c = p[2];
		o.out_pair_d = p[3];
		o.out_pair_e = p[4];
		o.out_pair_f = p[5];
		return o;
	endfunction

	function automatic logic [63:0] rand_word64();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic req_t build_req(input logic [1:0] kind, input logic [3:0] tgt,
			input logic [1:0] ts);
		req_t r;
		r.req_type = kind;
		r.target_slot = tgt;
		r.task_state_in = ts;
		r.page_dir_in = ($urandom_range(9) == 0) ? '1 : $urandom;
		r.frame_pair_a = rand_word64();
		r.frame_pair_b = rand_word64();
		r.frame_pair_c = rand_word64();
		r.frame_pair_d = rand_word64();
		r.frame_pair_e = rand_word64();
		r.frame_pair_f = rand_word64();
		return r;
	endfunction

	function automatic req_t with_frame(input req_t r, input logic [63:0] w);
		req_t o;
		o = r;
		{o.frame_pair_a, o.frame_pair_b, o.frame_pair_c,
			o.frame_pair_d, o.frame_pair_e, o.frame_pair_f} = {PAIRS{w}};
		return o;
	endfunction

	function automatic logic [1:0] rand_state();
		int unsigned v;
		v = $urandom_range(99);
		if (v < 40)
			return TS_READY;
		else if (v < 75)
			return TS_NOT_READY;
		else if (v < 90)
			return TS_RUNNING;
		return TS_ODD_CODE;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_req(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		switch_results_due.push_back(schedule_request(r));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		req_valid <= 1'b0;
		while (switch_results_due.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	task automatic diff_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (switch_results_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result with status %0d", got.status);
			return;
		end
		want = switch_results_due.pop_front();
		diff_field("status", 64'(want.status), 64'(got.status));
		diff_field("running_slot", 64'(want.running_slot), 64'(got.running_slot));
		diff_field("assigned_slot", 64'(want.assigned_slot), 64'(got.assigned_slot));
		diff_field("load_page_dir", 64'(want.load_page_dir), 64'(got.load_page_dir));
		diff_field("page_dir_out", 64'(want.page_dir_out), 64'(got.page_dir_out));
		diff_field("out_pair_a", want.out_pair_a, got.out_pair_a);
		diff_field("out_pair_b", want.out_pair_b, got.out_pair_b);
		diff_field("out_pair_c", want.out_pair_c, got.out_pair_c);
		diff_field("out_pair_d", want.out_pair_d, got.out_pair_d);
		diff_field("out_pair_e", want.out_pair_e, got.out_pair_e);
		diff_field("out_pair_f", want.out_pair_f, got.out_pair_f);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_result(rsp);
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic test_no_tasks();
		send_req(with_frame(build_req(REQ_TICK, 4'd0, TS_READY), '1));
		send_req(build_req(REQ_RESERVED, 4'd7, TS_RUNNING));
		send_req(build_req(REQ_SET, 4'd0, TS_NOT_READY));
		send_req(build_req(REQ_SET, 4'd15, TS_ODD_CODE));
	endtask

	task automatic test_single_task();
		req_t r;
		r = with_frame(build_req(REQ_ADD, 4'd0, TS_ODD_CODE), '0);
		r.page_dir_in = '1;
		send_req(r);
		// lone task with state code three is forced to running
		send_req(with_frame(build_req(REQ_TICK, 4'd0, TS_READY), '1));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
		send_req(build_req(REQ_SET, 4'd0, TS_NOT_READY));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
	endtask

	task automatic test_ring_order();
		req_t r;
		r = build_req(REQ_ADD, 4'd0, TS_READY);
		r.page_dir_in = '0;
		send_req(r);
		send_req(build_req(REQ_ADD, 4'd0, TS_NOT_READY));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
		// a running mark on a waiting slot does not make it eligible
		send_req(build_req(REQ_SET, 4'd2, TS_RUNNING));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
		send_req(build_req(REQ_SET, 4'd2, TS_READY));
		send_req(build_req(REQ_SET, 4'd0, TS_ODD_CODE));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
		send_req(build_req(REQ_TICK, 4'd0, TS_READY));
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count);
		int unsigned pick;
		logic [3:0] tgt;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (slots_used != 0 && $urandom_range(4) != 0)
				tgt = 4'($urandom_range(slots_used - 1));
			else
				tgt = 4'($urandom_range(15));
			if (pick < 45)
				send_req(build_req(REQ_TICK, 4'($urandom_range(15)), rand_state()));
			else if (pick < 84)
				send_req(build_req(REQ_SET, tgt, rand_state()));
			else if (pick < 88)
				send_req(build_req(REQ_ADD, 4'($urandom_range(15)), rand_state()));
			else if (pick < 93)
				send_req(build_req(REQ_RESERVED, 4'($urandom_range(15)), rand_state()));
			else
				send_req(build_req(REQ_SET, 4'($urandom_range(15)), rand_state()));
		end
		wait_drain();
	endtask

	task automatic test_table_full();
		send_idle_pct = 16;
		stall_pct = 16;
		while (slots_used < SLOTS)
			send_req(build_req(REQ_ADD, 4'($urandom_range(15)), rand_state()));
		send_req(build_req(REQ_ADD, 4'd0, TS_READY));
		send_req(with_frame(build_req(REQ_ADD, 4'd15, TS_ODD_CODE), '1));
		for (int i = 0; i < 20; i++) begin
			if (i % 2 == 0)
				send_req(build_req(REQ_TICK, 4'd0, TS_READY));
			else
				send_req(build_req(REQ_SET, 4'($urandom_range(15)), rand_state()));
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_no_tasks();
		test_single_task();
		test_ring_order();
		wait_drain();
		test_random_traffic(0, 0, 120);
		test_random_traffic(58, 0, 120);
		test_random_traffic(0, 58, 120);
		test_random_traffic(16, 16, 120);
		test_table_full();
		wait_drain();
		repeat (60) @(negedge clk);
		fail_count += switch_results_due.size();
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rrcs_pkg.sv
rtl/round_robin_context_switcher.sv
bench/tb.sv
